FILE: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/svpwm_pkg.sv
package svpwm_pkg;

   localparam int TIME_WIDTH_DEF = 16;
   localparam int WIDTH_BITS     = 16;
   localparam int REPEAT_BITS    = 8;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [15:0] PERIOD_RST = 16'd20000;
   localparam logic [15:0] HOLD_RST   = 16'd1500;
   localparam logic [15:0] MIN_RST    = 16'd1010;
   localparam logic [15:0] MAX_RST    = 16'd1990;
   localparam logic [15:0] STEP_RST   = 16'd10;
   localparam logic [7:0]  PPP_RST    = 8'd5;

   typedef enum logic [2:0] {
      REG_SWEEP_ENABLE = 3'd0,
      REG_PERIOD       = 3'd1,
      REG_HOLD_PULSE   = 3'd2,
      REG_SWEEP_MIN    = 3'd3,
      REG_SWEEP_MAX    = 3'd4,
      REG_SWEEP_STEP   = 3'd5,
      REG_PULSES_PER   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic        sweep_enable;
      logic [15:0] period_us;
      logic [15:0] hold_pulse_us;
      logic [15:0] sweep_min_us;
      logic [15:0] sweep_max_us;
      logic [15:0] sweep_step_us;
      logic [7:0]  pulses_per_position;
   } cfg_type;

   typedef struct packed {
      logic        line_level;
      logic [15:0] width_now_us;
      logic        frame_start;
   } res_type;

endpackage

FILE: rtl/core/svpwm_csr.sv
module svpwm_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [svpwm_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [svpwm_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [svpwm_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output svpwm_pkg::cfg_type                     cfg
);
   import svpwm_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SWEEP_ENABLE: cfg_in.sweep_enable        = csr_pwdata[0];
            REG_PERIOD:       cfg_in.period_us           = csr_pwdata[15:0];
            REG_HOLD_PULSE:   cfg_in.hold_pulse_us       = csr_pwdata[15:0];
            REG_SWEEP_MIN:    cfg_in.sweep_min_us        = csr_pwdata[15:0];
            REG_SWEEP_MAX:    cfg_in.sweep_max_us        = csr_pwdata[15:0];
            REG_SWEEP_STEP:   cfg_in.sweep_step_us       = csr_pwdata[15:0];
            REG_PULSES_PER:   cfg_in.pulses_per_position = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SWEEP_ENABLE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.sweep_enable);
         REG_PERIOD:       csr_prdata = CSR_DATA_WIDTH'(cfg_ff.period_us);
         REG_HOLD_PULSE:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hold_pulse_us);
         REG_SWEEP_MIN:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.sweep_min_us);
         REG_SWEEP_MAX:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.sweep_max_us);
         REG_SWEEP_STEP:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.sweep_step_us);
         REG_PULSES_PER:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.pulses_per_position);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_enable        <= 1'b0;
         cfg_ff.period_us           <= PERIOD_RST;
         cfg_ff.hold_pulse_us       <= HOLD_RST;
         cfg_ff.sweep_min_us        <= MIN_RST;
         cfg_ff.sweep_max_us        <= MAX_RST;
         cfg_ff.sweep_step_us       <= STEP_RST;
         cfg_ff.pulses_per_position <= PPP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/svpwm_core.sv
module svpwm_core #(
   parameter int TIME_WIDTH = svpwm_pkg::TIME_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  svpwm_pkg::cfg_type cfg,
   input  logic               advance,
   input  logic               run,
   output svpwm_pkg::res_type res
);
   import svpwm_pkg::*;

   localparam int CW = (TIME_WIDTH > WIDTH_BITS) ? TIME_WIDTH : WIDTH_BITS;

   logic [TIME_WIDTH-1:0]  tick_ff, tick_in, eff_tick, next_tick;
   logic [WIDTH_BITS-1:0]  sw_ff, sw_in, eff_sw, width, period, step;
   logic [REPEAT_BITS-1:0] rep_ff, rep_in, eff_rep, rep_inc, ppp;
   logic                   down_ff, down_in, eff_down;
   logic                   was_ff, was_in;
   logic                   blocked, wrap;
   logic [WIDTH_BITS:0]    up_sum, min_plus;

   always_comb begin
      // a fresh run restarts the sequence before this tick is used
      eff_tick = was_ff ? tick_ff : '0;
      eff_sw   = was_ff ? sw_ff   : cfg.sweep_min_us;
      eff_down = was_ff ? down_ff : 1'b0;
      eff_rep  = was_ff ? rep_ff  : '0;

      period  = (cfg.period_us != '0) ? cfg.period_us : WIDTH_BITS'(1);
      step    = (cfg.sweep_step_us != '0) ? cfg.sweep_step_us : WIDTH_BITS'(1);
      ppp     = (cfg.pulses_per_position != '0) ? cfg.pulses_per_position
                                                : REPEAT_BITS'(1);
      blocked = cfg.sweep_enable && (cfg.sweep_min_us > cfg.sweep_max_us);
      width   = blocked ? '0 : (cfg.sweep_enable ? eff_sw : cfg.hold_pulse_us);

      next_tick = eff_tick + TIME_WIDTH'(1);
      wrap      = (next_tick == '0) || (CW'(next_tick) >= CW'(period));
      rep_inc   = eff_rep + REPEAT_BITS'(1);
      up_sum    = {1'b0, eff_sw} + {1'b0, step};
      min_plus  = {1'b0, cfg.sweep_min_us} + {1'b0, step};

      res.line_level   = run && (CW'(eff_tick) < CW'(width));
      res.width_now_us = run ? width : '0;
      res.frame_start  = run && (eff_tick == '0);

      tick_in = wrap ? '0 : next_tick;
      sw_in   = eff_sw;
      down_in = eff_down;
      rep_in  = eff_rep;
      was_in  = 1'b1;
      if (!run) begin
         tick_in = '0;
         sw_in   = cfg.sweep_min_us;
         down_in = 1'b0;
         rep_in  = '0;
         was_in  = 1'b0;
      end else if (blocked) begin
         sw_in   = cfg.sweep_min_us;
         down_in = 1'b0;
         rep_in  = '0;
      end else if (wrap && cfg.sweep_enable) begin
         if (rep_inc >= ppp) begin
            rep_in = '0;
            if (!eff_down) begin
               if (up_sum > {1'b0, cfg.sweep_max_us}) begin
                  sw_in   = cfg.sweep_max_us;
                  down_in = 1'b1;
               end else begin
                  sw_in = up_sum[WIDTH_BITS-1:0];
               end
            end else begin
               if ({1'b0, eff_sw} < min_plus) begin
                  sw_in   = cfg.sweep_min_us;
                  down_in = 1'b0;
               end else begin
                  sw_in = eff_sw - step;
               end
            end
         end else begin
            rep_in = rep_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         sw_ff   <= '0;
         down_ff <= 1'b0;
         rep_ff  <= '0;
         was_ff  <= 1'b0;
      end else if (advance) begin
         tick_ff <= tick_in;
         sw_ff   <= sw_in;
         down_ff <= down_in;
         rep_ff  <= rep_in;
         was_ff  <= was_in;
      end
   end

endmodule

FILE: rtl/core/servo_pwm_sweep_generator.sv
// servo pulse generator: each accepted req beat is one microsecond tick and
// yields exactly one rsp beat with the line level, the pulse width of the
// current frame and a frame start flag. a tick with run low forces the line
// low and restarts the frame and the sweep. the block takes one beat per
// cycle while the result register is free or being taken; a tick sits in
// the input register until the result register can take it, then moves
// there, and its rsp beat is offered from the result register. the frame
// counter, sweep width, direction and repeat count update in the cycle the
// tick leaves the input register, which keeps back-to-back ticks correct.
// configuration sits behind an apb-style port, registers at byte addresses
// 0x00 mode, 0x04 period, 0x08 hold width, 0x0c sweep min, 0x10 sweep max,
// 0x14 sweep step, 0x18 pulses per position; write them only while idle.
module servo_pwm_sweep_generator #(
   parameter int TIME_WIDTH = svpwm_pkg::TIME_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_run,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_line_level,
   output logic [15:0]                          rsp_width_now_us,
   output logic                                 rsp_frame_start,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [svpwm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [svpwm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [svpwm_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import svpwm_pkg::*;
`include "assert_macros.svh"

   cfg_type cfg;
   res_type res, res_ff, res_in;

   logic in_valid_ff, in_valid_in;
   logic run_ff, run_in;
   logic out_valid_ff, out_valid_in;
   logic out_en, req_take, advance;

   svpwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   svpwm_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .run     (run_ff),
      .res     (res)
   );

   // result register frees up when empty or being taken this cycle
   assign out_en    = !out_valid_ff || !rsp_stall;
   // input register holds only when its tick cannot move on
   assign req_stall = in_valid_ff && !out_en;
   assign req_take  = req_valid && !req_stall;
   // tick moves into the result register and the counters step
   assign advance   = in_valid_ff && out_en;

   always_comb begin
      in_valid_in  = in_valid_ff;
      run_in       = run_ff;
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         run_in = req_run;
      end
      if (out_en) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         res_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      run_ff <= run_in;
      res_ff <= res_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_level   = res_ff.line_level;
   assign rsp_width_now_us = res_ff.width_now_us;
   assign rsp_frame_start  = res_ff.frame_start;

   // a stalled input always means a result is waiting on a stalled output
   `ASSERT_RUN(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "req stall without rsp backpressure")
   // no result comes out of reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid right after reset")
   // the first tick of a frame is high whenever the width is nonzero
   `ASSERT_RUN(a_frame_high, clock, reset, (rsp_valid && rsp_frame_start && (rsp_width_now_us != 16'd0)) |-> rsp_line_level, "frame start low with nonzero width")

endmodule

FILE: dv/tb_servo_pwm_sweep_generator.sv
module tb_servo_pwm_sweep_generator;
   import svpwm_pkg::*;

   localparam int TICK_BITS       = TIME_WIDTH_DEF;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 4;     // beat passes through the input and result registers
   localparam int HOLD_OFF_CYCLES = 64;    // long receiver hold-off, fills the block
   localparam int RANDOM_PHASES   = 9;
   localparam int TICKS_PER_PHASE = 50;
   localparam int HOLD_OFF_PHASE  = 2;
   localparam int WATCHDOG_LIMIT  = 2000;

   // predictor of the pulse generator plus the queue of result beats it expects
   class pulse_scoreboard;
      cfg_type                settings;
      logic [TICK_BITS-1:0]   frame_tick;
      logic [15:0]            sweep_width;
      logic                   sweep_down;
      logic [7:0]             repeat_count;
      logic                   running;
      res_type                expected_beats[$];
      int unsigned            mismatches;
      int unsigned            ticks_running;
      int unsigned            ticks_stopped;
      int unsigned            frame_starts;
      int unsigned            reversals;

      function new();
         settings = '{sweep_enable: 1'b0, period_us: PERIOD_RST, hold_pulse_us: HOLD_RST,
                      sweep_min_us: MIN_RST, sweep_max_us: MAX_RST,
                      sweep_step_us: STEP_RST, pulses_per_position: PPP_RST};
         frame_tick   = '0;
         sweep_width  = '0;
         sweep_down   = 1'b0;
         repeat_count = '0;
         running      = 1'b0;
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      function void restart_sweep();
         frame_tick   = '0;
         sweep_width  = settings.sweep_min_us;
         sweep_down   = 1'b0;
         repeat_count = '0;
      endfunction

      function void next_position();
         logic [16:0] stride;
         logic [16:0] climbed;
         stride = (settings.sweep_step_us == 16'd0) ? 17'd1 : {1'b0, settings.sweep_step_us};
         if (!sweep_down) begin
            climbed = {1'b0, sweep_width} + stride;
            if (climbed > {1'b0, settings.sweep_max_us}) begin
               sweep_width = settings.sweep_max_us;
               sweep_down  = 1'b1;
               reversals++;
            end else begin
               sweep_width = climbed[15:0];
            end
         end else if ({1'b0, sweep_width} < {1'b0, settings.sweep_min_us} + stride) begin
            sweep_width = settings.sweep_min_us;
            sweep_down  = 1'b0;
            reversals++;
         end else begin
            sweep_width = sweep_width - stride[15:0];
         end
      endfunction

      // one accepted tick: queue the beat it must produce and advance the frame
      function void note_tick(logic run);
         res_type              beat;
         logic [15:0]          period;
         logic [15:0]          width;
         logic [TICK_BITS-1:0] following;
         logic [7:0]           per_position;
         logic                 blocked;
         if (!run) begin
            restart_sweep();
            running = 1'b0;
            beat    = '0;
            expected_beats.push_back(beat);
            ticks_stopped++;
            return;
         end
         if (!running) begin
            restart_sweep();
            running = 1'b1;
         end
         ticks_running++;
         period  = (settings.period_us == 16'd0) ? 16'd1 : settings.period_us;
         blocked = settings.sweep_enable && (settings.sweep_min_us > settings.sweep_max_us);
         if (blocked) begin
            sweep_width  = settings.sweep_min_us;
            sweep_down   = 1'b0;
            repeat_count = '0;
            width        = '0;
         end else begin
            width = settings.sweep_enable ? sweep_width : settings.hold_pulse_us;
         end
         beat.line_level   = (frame_tick < width);
         beat.width_now_us = width;
         beat.frame_start  = (frame_tick == '0);
         if (beat.frame_start) frame_starts++;
         expected_beats.push_back(beat);

         following = frame_tick + 1'b1;
         if (following == '0 || following >= period) begin
            frame_tick = '0;
            if (settings.sweep_enable && !blocked) begin
               per_position = (settings.pulses_per_position == 8'd0) ?
                              8'd1 : settings.pulses_per_position;
               repeat_count = repeat_count + 8'd1;
               if (repeat_count >= per_position) begin
                  repeat_count = '0;
                  next_position();
               end
            end
         end else begin
            frame_tick = following;
         end
      endfunction

      function void check_beat(res_type got);
         res_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: line %0b width %0d start %0b",
                   got.line_level, got.width_now_us, got.frame_start);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
            mismatches++;
         end
         if (got.width_now_us !== want.width_now_us) begin
            $error("width_now_us: expected %0d, got %0d", want.width_now_us, got.width_now_us);
            mismatches++;
         end
         if (got.frame_start !== want.frame_start) begin
            $error("frame_start: expected %0b, got %0b", want.frame_start, got.frame_start);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_run;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_line_level;
   logic [15:0]               rsp_width_now_us;
   logic                      rsp_frame_start;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   pulse_scoreboard sb;
   bit              sender_fast;       // no gaps between sender beats
   bit              rsp_fast;          // receiver never stalls on its own
   bit              hold_off_pending;  // main flow asks the receiver for a long hold-off
   int unsigned     idle_cycles;
   int unsigned     settings_applied;

   servo_pwm_sweep_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_run          (req_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_level   (rsp_line_level),
      .rsp_width_now_us (rsp_width_now_us),
      .rsp_frame_start  (rsp_frame_start),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // both channels are watched at the edge where the beat moves; the predictor
   // sees a tick before the result beat it causes can show up
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid && !req_stall) sb.note_tick(req_run);
         if (rsp_valid && !rsp_stall)
            sb.check_beat('{line_level: rsp_line_level, width_now_us: rsp_width_now_us,
                            frame_start: rsp_frame_start});
      end
   end

   // watchdog: too long without any beat on either side ends the run
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver: random stall before each beat, a long hold-off when asked
   initial begin : receiver
      int unsigned gap;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = rsp_fast ? 0 : $urandom_range(0, 7);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // one tick beat; valid stays high into the next call when it has no gap
   task automatic send_tick(input logic run);
      int unsigned gap;
      gap = sender_fast ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_run   <= run;
      do @(posedge clock); while (req_stall);
   endtask

   // sender pauses until every expected beat is back, then lets the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle then access; psel stays up between back-to-back writes
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // settles the block first, so the registers are written with the block idle
   task automatic apply_settings(input cfg_type c);
      settle();
      write_reg(REG_SWEEP_ENABLE, CSR_DATA_WIDTH'(c.sweep_enable));
      write_reg(REG_PERIOD,       CSR_DATA_WIDTH'(c.period_us));
      write_reg(REG_HOLD_PULSE,   CSR_DATA_WIDTH'(c.hold_pulse_us));
      write_reg(REG_SWEEP_MIN,    CSR_DATA_WIDTH'(c.sweep_min_us));
      write_reg(REG_SWEEP_MAX,    CSR_DATA_WIDTH'(c.sweep_max_us));
      write_reg(REG_SWEEP_STEP,   CSR_DATA_WIDTH'(c.sweep_step_us));
      write_reg(REG_PULSES_PER,   CSR_DATA_WIDTH'(c.pulses_per_position));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.settings = c;
      settings_applied++;
   endtask

   // mostly short periods so frames and sweep steps turn over quickly;
   // now and then a full-range value so every register bit gets exercised
   function automatic cfg_type draw_settings();
      cfg_type     c;
      int unsigned span;
      c.sweep_enable  = 1'($urandom_range(0, 1));
      c.period_us     = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      span            = (c.period_us < 16'd30) ? int'(c.period_us) + 2 : 30;
      c.hold_pulse_us = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      c.sweep_min_us  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      // sometimes an unrelated maximum, which may sit below the minimum
      c.sweep_max_us  = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                        16'(int'(c.sweep_min_us) + $urandom_range(0, span));
      c.sweep_step_us = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      c.pulses_per_position = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                              8'($urandom_range(0, 3));
      return c;
   endfunction

   initial begin : stimulus
      cfg_type c;
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_run          = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      sender_fast      = 1'b0;
      rsp_fast         = 1'b0;
      hold_off_pending = 1'b0;
      idle_cycles      = 0;
      settings_applied = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: a stopped tick, then the start of the first frame
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);

      // period zero counts as one tick, zero hold width keeps the line low
      c = sb.settings;
      c.period_us     = 16'd0;
      c.hold_pulse_us = 16'd0;
      apply_settings(c);
      send_tick(1'b1);
      send_tick(1'b1);

      // width past the period keeps the line high through the frame
      c.period_us     = 16'd3;
      c.hold_pulse_us = 16'hffff;
      apply_settings(c);
      repeat (3) send_tick(1'b1);

      // sweep minimum above maximum: no pulses, frame flag keeps counting
      c.sweep_enable = 1'b1;
      c.sweep_min_us = 16'd5;
      c.sweep_max_us = 16'd2;
      apply_settings(c);
      repeat (3) send_tick(1'b1);

      // full-range sweep with the largest step, zero repeats count as one;
      // a stop in the middle restarts from the minimum
      c.period_us           = 16'd2;
      c.sweep_min_us        = 16'd0;
      c.sweep_max_us        = 16'hffff;
      c.sweep_step_us       = 16'hffff;
      c.pulses_per_position = 8'd0;
      apply_settings(c);
      repeat (6) send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // zero step counts as one, turning at the top of the width range
      c.period_us           = 16'd1;
      c.sweep_min_us        = 16'hfffe;
      c.sweep_step_us       = 16'd0;
      c.pulses_per_position = 8'd1;
      apply_settings(c);
      repeat (5) send_tick(1'b1);

      // random phases: mostly running ticks with the odd stop
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(draw_settings());
         sender_fast = (phase == HOLD_OFF_PHASE) || ($urandom_range(0, 3) == 0);
         rsp_fast    = ($urandom_range(0, 3) == 0);
         if (phase == HOLD_OFF_PHASE) hold_off_pending = 1'b1;
         for (int k = 0; k < TICKS_PER_PHASE; k++) send_tick($urandom_range(0, 11) != 0);
      end

      settle();
      $display("covered %0d running and %0d stopped ticks under %0d register settings",
               sb.ticks_running, sb.ticks_stopped, settings_applied);
      $display("saw %0d frame starts and %0d sweep direction changes",
               sb.frame_starts, sb.reversals);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_csr.sv
rtl/core/svpwm_core.sv
rtl/core/servo_pwm_sweep_generator.sv
dv/tb_servo_pwm_sweep_generator.sv
